### hdl/lkf_pkg.sv
// ----------------------------------------------------------------------------
// lkf_pkg
// Shared types and constants for the line keyword filter.
// ----------------------------------------------------------------------------
package lkf_pkg;

  localparam int KEY_CHARS  = 8;   // characters held by the keyword register
  localparam int LEN_W      = 4;
  localparam int OUT_CNT_W  = 48;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 64;

  localparam logic [7:0] NEWLINE_BYTE = 8'd10;
  localparam logic [7:0] ZERO_BYTE    = 8'd0;

  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_EOF  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_KEYWORD_BYTES  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KEYWORD_LENGTH = 1'b1;

  typedef logic [7:0]                  byte_t;
  typedef logic [KEY_CHARS-1:0][7:0]   key_chars_t;
  typedef logic [LEN_W-1:0]            key_len_t;
  typedef logic [OUT_CNT_W-1:0]        out_cnt_t;

  // line events handed to the match unit, one set per processed word
  typedef struct packed {
    logic  take;   // non-zero, non-newline byte joins the line
    logic  zero;   // zero byte: stop matching for the rest of the line
    logic  clr;    // newline or end of file
    byte_t data;
  } line_ev_t;

endpackage

### hdl/lkf_if.sv
// ----------------------------------------------------------------------------
// lkf_in_if / lkf_out_if
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface lkf_in_if;
  logic             valid;
  logic             ready;
  logic             cmd;
  lkf_pkg::byte_t   data_byte;

  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

interface lkf_out_if;
  logic              valid;
  logic              ready;
  logic              line_matched;
  lkf_pkg::out_cnt_t line_total;
  lkf_pkg::out_cnt_t hit_total;

  modport source (output valid, output line_matched, output line_total,
                  output hit_total, input ready);
  modport sink   (input valid, input line_matched, input line_total,
                  input hit_total, output ready);
endinterface

### hdl/lkf_cfg_regs.sv
// ----------------------------------------------------------------------------
// lkf_cfg_regs
// Keyword registers and effective keyword length.
// ----------------------------------------------------------------------------
module lkf_cfg_regs #(
  parameter int MAX_KEY = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [lkf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lkf_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output lkf_pkg::key_chars_t                 key_chars,
  output lkf_pkg::key_len_t                   key_len
);

  localparam int CAP = (MAX_KEY < lkf_pkg::KEY_CHARS) ? MAX_KEY : lkf_pkg::KEY_CHARS;

  lkf_pkg::key_chars_t key_r;
  lkf_pkg::key_len_t   klen_r;
  lkf_pkg::key_len_t   cap_len;
  lkf_pkg::key_len_t   eff_len;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r  <= '0;
      klen_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        lkf_pkg::REG_KEYWORD_BYTES:  key_r  <= cfg_wdata;
        lkf_pkg::REG_KEYWORD_LENGTH: klen_r <= cfg_wdata[lkf_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // length clipped to the cap, then cut at the first zero character
  always_comb begin
    cap_len = (klen_r > lkf_pkg::LEN_W'(CAP)) ? lkf_pkg::LEN_W'(CAP) : klen_r;
    eff_len = cap_len;
    for (int i = lkf_pkg::KEY_CHARS - 1; i >= 0; i--) begin
      if ((lkf_pkg::LEN_W'(i) < cap_len) && (key_r[i] == lkf_pkg::ZERO_BYTE)) begin
        eff_len = lkf_pkg::LEN_W'(i);
      end
    end
  end

  assign key_chars = key_r;
  assign key_len   = eff_len;

endmodule

### hdl/lkf_line_match.sv
// ----------------------------------------------------------------------------
// lkf_line_match
// Sliding window of the current line and parallel keyword compare.
// ----------------------------------------------------------------------------
module lkf_line_match #(
  parameter int MAX_KEY = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lkf_pkg::line_ev_t    ev,
  input  lkf_pkg::key_chars_t  key_chars,
  input  lkf_pkg::key_len_t    key_len,
  output logic                 found
);

  localparam int CAP    = (MAX_KEY < lkf_pkg::KEY_CHARS) ? MAX_KEY : lkf_pkg::KEY_CHARS;
  localparam int WIN    = (CAP > 1) ? CAP - 1 : 1;
  localparam int FILL_W = (CAP > 1) ? $clog2(CAP) : 1;

  lkf_pkg::byte_t        window_r [WIN];
  logic [FILL_W-1:0]     fill_r;
  logic                  found_r;
  logic                  zero_seen_r;
  logic                  hit;

  // window_r[0] is the latest byte; compare against the keyword tail
  always_comb begin
    hit = (key_len != '0)
       && ((lkf_pkg::LEN_W'(fill_r) + lkf_pkg::LEN_W'(1)) >= key_len)
       && (ev.data == key_chars[3'(key_len - lkf_pkg::LEN_W'(1))]);
    for (int i = 1; i < CAP; i++) begin
      if ((lkf_pkg::LEN_W'(i) < key_len) &&
          (window_r[i-1] != key_chars[3'(key_len - lkf_pkg::LEN_W'(1)
                                         - lkf_pkg::LEN_W'(i))])) begin
        hit = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      found_r     <= 1'b0;
      zero_seen_r <= 1'b0;
    end else if (ev.clr) begin
      fill_r      <= '0;
      found_r     <= 1'b0;
      zero_seen_r <= 1'b0;
    end else if (ev.zero) begin
      zero_seen_r <= 1'b1;
    end else if (ev.take && !zero_seen_r) begin
      if (hit) begin
        found_r <= 1'b1;
      end
      if (fill_r != FILL_W'(CAP - 1)) begin
        fill_r <= fill_r + FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ev.take && !ev.clr && !ev.zero && !zero_seen_r) begin
      window_r[0] <= ev.data;
      for (int k = WIN - 1; k > 0; k--) begin
        window_r[k] <= window_r[k-1];
      end
    end
  end

  assign found = found_r;

endmodule

### hdl/line_keyword_filter_top.sv
// ----------------------------------------------------------------------------
// line_keyword_filter_top
// Fixed-string line filter over a byte stream with saturating line counts.
// ----------------------------------------------------------------------------
// Input channel in_ch carries one word per byte: cmd selects a text byte or
// end of file. A newline closes the line and yields one result word on
// out_ch: the match flag and the running counts of lines read and saved.
// Other bytes and end of file yield no result; end of file drops the
// unfinished line. The keyword (up to 8 characters) and its length are set
// through the cfg_ write port while the filter is idle.
// A newline word accepted into the input register goes on through the result
// register to out_ch. Throughput: one word per cycle while no newline waits on
// a stalled receiver, set by the combinational keyword window compare.
// When the receiver stalls, the result register holds its word; the input
// register fills behind it and in_ch.ready drops only while a newline waits
// for the result register. Non-newline words keep flowing under a stall.
// Synchronous reset clears the keyword, the line state and both counters.
// ----------------------------------------------------------------------------
module line_keyword_filter_top #(
  parameter int MAX_KEY    = 8,
  parameter int COUNT_BITS = 48
) (
  input  logic                             clk,
  input  logic                             rst_n,
  lkf_in_if.sink                           in_ch,
  lkf_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [lkf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lkf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  logic                    s1_v_r;
  logic                    s1_cmd_r;
  lkf_pkg::byte_t          s1_byte_r;

  logic                    is_nl;
  logic                    is_zero;
  logic                    advance;
  lkf_pkg::line_ev_t       ev;
  lkf_pkg::key_chars_t     key_chars;
  lkf_pkg::key_len_t       key_len;
  logic                    found;
  logic                    matched;

  logic [COUNT_BITS-1:0]   read_cnt_r;
  logic [COUNT_BITS-1:0]   saved_cnt_r;
  logic [COUNT_BITS-1:0]   read_cnt_nxt;
  logic [COUNT_BITS-1:0]   saved_cnt_nxt;

  logic                    out_v_r;
  logic                    out_match_r;
  lkf_pkg::out_cnt_t       out_read_r;
  lkf_pkg::out_cnt_t       out_saved_r;

  lkf_cfg_regs #(.MAX_KEY(MAX_KEY)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .key_chars (key_chars),
    .key_len   (key_len)
  );

  // input register
  assign in_ch.ready = !s1_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_cmd_r  <= in_ch.cmd;
      s1_byte_r <= in_ch.data_byte;
    end
  end

  // decode
  assign is_nl   = (s1_cmd_r == lkf_pkg::CMD_DATA) && (s1_byte_r == lkf_pkg::NEWLINE_BYTE);
  assign is_zero = (s1_cmd_r == lkf_pkg::CMD_DATA) && (s1_byte_r == lkf_pkg::ZERO_BYTE);
  assign advance = s1_v_r && (!is_nl || !out_v_r || out_ch.ready);

  always_comb begin
    ev.data = s1_byte_r;
    ev.clr  = advance && (is_nl || (s1_cmd_r == lkf_pkg::CMD_EOF));
    ev.zero = advance && is_zero;
    ev.take = advance && (s1_cmd_r == lkf_pkg::CMD_DATA) && !is_nl && !is_zero;
  end

  lkf_line_match #(.MAX_KEY(MAX_KEY)) u_match (
    .clk       (clk),
    .rst_n     (rst_n),
    .ev        (ev),
    .key_chars (key_chars),
    .key_len   (key_len),
    .found     (found)
  );

  assign matched = found || (key_len == '0);

  // saturating counters
  always_comb begin
    read_cnt_nxt  = (&read_cnt_r) ? read_cnt_r : read_cnt_r + COUNT_BITS'(1);
    saved_cnt_nxt = saved_cnt_r;
    if (matched && !(&saved_cnt_r)) begin
      saved_cnt_nxt = saved_cnt_r + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_cnt_r  <= '0;
      saved_cnt_r <= '0;
    end else if (advance && is_nl) begin
      read_cnt_r  <= read_cnt_nxt;
      saved_cnt_r <= saved_cnt_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance && is_nl) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && is_nl) begin
      out_match_r <= matched;
      out_read_r  <= lkf_pkg::OUT_CNT_W'(read_cnt_nxt);
      out_saved_r <= lkf_pkg::OUT_CNT_W'(saved_cnt_nxt);
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.line_matched = out_match_r;
  assign out_ch.line_total   = out_read_r;
  assign out_ch.hit_total    = out_saved_r;

endmodule
